// File: rtl/rfr_pkg.sv
// rfr_pkg: shared constants and types for the radio frame receiver
// no dependencies; used by the top level
`timescale 1ns / 1ps

package rfr_pkg;

  localparam logic [7:0] HDR_INDIVIDUAL = 8'hFD;
  localparam logic [7:0] HDR_BROADCAST  = 8'h00;
  localparam logic [7:0] OP_SETTINGS    = 8'h00;
  localparam logic [7:0] OP_HELLO       = 8'h01;

  localparam int unsigned CNT_W      = 9;
  localparam int unsigned HEAD_DEPTH = 4;

  // byte offset of the first payload byte inside the frame
  localparam logic [CNT_W-1:0] START_INDIVIDUAL = CNT_W'(4);
  localparam logic [CNT_W-1:0] START_BROADCAST  = CNT_W'(2);

  typedef enum logic [2:0] {
    OUT_BCAST_OK   = 3'd0,
    OUT_INDIV_OK   = 3'd1,
    OUT_MALFORMED  = 3'd2,
    OUT_UNKNOWN    = 3'd3,
    OUT_NOT_COORD  = 3'd4
  } outcome_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_LENGTH = 3'b010,
    PH_BODY   = 3'b100
  } phase_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [7:0]  frame_header;
    logic [7:0]  opcode;
    logic [15:0] source_address;
    logic [7:0]  payload_length;
    logic        settings_updated;
    logic [7:0]  light_sensor_on;
    logic [7:0]  motion_sensor_on;
    logic [7:0]  mute_on;
    logic        hello_request;
  } result_t;

endpackage

// File: rtl/rfr_ifs.sv
// rfr_ifs: valid/ready channel interfaces for received bytes and frame results
// no dependencies
`timescale 1ns / 1ps

interface rfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfr_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  outcome;
  logic [7:0]  frame_header;
  logic [7:0]  opcode;
  logic [15:0] source_address;
  logic [7:0]  payload_length;
  logic        settings_updated;
  logic [7:0]  light_sensor_on;
  logic [7:0]  motion_sensor_on;
  logic [7:0]  mute_on;
  logic        hello_request;

  modport source (
    output valid, output outcome, output frame_header, output opcode,
    output source_address, output payload_length, output settings_updated,
    output light_sensor_on, output motion_sensor_on, output mute_on,
    output hello_request, input ready
  );
  modport sink (
    input valid, input outcome, input frame_header, input opcode,
    input source_address, input payload_length, input settings_updated,
    input light_sensor_on, input motion_sensor_on, input mute_on,
    input hello_request, output ready
  );
endinterface

// File: rtl/radio_module_frame_receiver_unit.sv
// radio_module_frame_receiver_unit: frames received bytes and reports one result per frame
// depends on rfr_pkg and the channel interfaces in rfr_ifs.sv
// the result of a frame is registered in the output register, or in the skid entry while a result waits downstream
// throughput: one byte per cycle unless the skid entry is full; a two-entry output
//   register and skid stage keep the byte side running while one result waits downstream
// reset: synchronous active-low rst_n clears framing state, settings and
//   the output stage valid flags; no clearing pass, ready right after reset
`timescale 1ns / 1ps

module radio_module_frame_receiver_unit (
  input  logic               clk,
  input  logic               rst_n,
  rfr_byte_if.sink           in_ch,
  rfr_result_if.source       out_ch
);

  localparam int unsigned CW = rfr_pkg::CNT_W;

  rfr_pkg::phase_t    phase_r, phase_nxt;
  logic [7:0]         header_r, header_nxt;
  logic [7:0]         length_r, length_nxt;
  logic [CW-1:0]      left_r, left_nxt;
  logic [CW-1:0]      pos_r, pos_nxt;
  logic [15:0]        tail_r, tail_nxt;
  logic [7:0]         head_r [rfr_pkg::HEAD_DEPTH];
  logic [7:0]         head_nxt [rfr_pkg::HEAD_DEPTH];
  logic [7:0]         set_r [3];
  logic [7:0]         set_nxt [3];

  rfr_pkg::result_t   res;
  logic               res_fire;

  rfr_pkg::result_t   out_r, skid_r;
  logic               out_vld_r, skid_vld_r;

  logic               in_fire, pop;
  logic               is_indiv, known;
  logic [CW-1:0]      start, k;

  assign in_ch.ready = !skid_vld_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign pop         = out_vld_r && out_ch.ready;

  assign is_indiv = (header_r == rfr_pkg::HDR_INDIVIDUAL);
  assign known    = is_indiv || (header_r == rfr_pkg::HDR_BROADCAST);
  assign start    = is_indiv ? rfr_pkg::START_INDIVIDUAL : rfr_pkg::START_BROADCAST;
  assign k        = pos_r - start;

  // per-byte framing step
  always_comb begin
    phase_nxt = phase_r;
    header_nxt = header_r;
    length_nxt = length_r;
    left_nxt = left_r;
    pos_nxt = pos_r;
    tail_nxt = tail_r;
    head_nxt = head_r;
    set_nxt = set_r;
    res_fire = 1'b0;
    res = '0;
    if (in_fire) begin
      pos_nxt = pos_r + CW'(1);
      case (phase_r)
        rfr_pkg::PH_LENGTH: begin
          length_nxt = in_ch.rx_byte;
          left_nxt = CW'(in_ch.rx_byte) + start;
          phase_nxt = rfr_pkg::PH_BODY;
        end
        rfr_pkg::PH_BODY: begin
          // payload bytes sit after the header/length (and, in individual frames, the unused address pair)
          if (known && pos_r >= start && k < CW'(rfr_pkg::HEAD_DEPTH)
              && k < CW'(length_r)) begin
            head_nxt[k[1:0]] = in_ch.rx_byte;
          end
          tail_nxt = {tail_r[7:0], in_ch.rx_byte};
          left_nxt = left_r - CW'(1);
          if (left_nxt == '0) begin
            res_fire = 1'b1;
            phase_nxt = rfr_pkg::PH_HEADER;
            pos_nxt = '0;
            res.frame_header = header_r;
            res.source_address = tail_nxt;
            res.payload_length = length_r;
            if (!known) begin
              res.outcome = rfr_pkg::OUT_UNKNOWN;
            end else if (length_r == 8'd0) begin
              res.outcome = rfr_pkg::OUT_MALFORMED;
            end else begin
              res.opcode = head_nxt[0];
              if (is_indiv) begin
                if (tail_nxt != 16'd0) begin
                  res.outcome = rfr_pkg::OUT_NOT_COORD;
                end else begin
                  res.outcome = rfr_pkg::OUT_INDIV_OK;
                  if (head_nxt[0] == rfr_pkg::OP_SETTINGS && length_r >= 8'd4) begin
                    set_nxt[0] = head_nxt[1];
                    set_nxt[1] = head_nxt[2];
                    set_nxt[2] = head_nxt[3];
                    res.settings_updated = 1'b1;
                  end
                  res.hello_request = (head_nxt[0] == rfr_pkg::OP_HELLO);
                end
              end else begin
                res.outcome = rfr_pkg::OUT_BCAST_OK;
                res.hello_request = (head_nxt[0] == rfr_pkg::OP_HELLO);
              end
            end
            res.light_sensor_on = set_nxt[0];
            res.motion_sensor_on = set_nxt[1];
            res.mute_on = set_nxt[2];
          end
        end
        default: begin
          header_nxt = in_ch.rx_byte;
          pos_nxt = CW'(1);
          phase_nxt = rfr_pkg::PH_LENGTH;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rfr_pkg::PH_HEADER;
      header_r <= '0;
      length_r <= '0;
      left_r <= '0;
      pos_r <= '0;
      tail_r <= '0;
      for (int i = 0; i < 3; i++) set_r[i] <= '0;
    end else begin
      phase_r <= phase_nxt;
      header_r <= header_nxt;
      length_r <= length_nxt;
      left_r <= left_nxt;
      pos_r <= pos_nxt;
      tail_r <= tail_nxt;
      set_r <= set_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        out_r <= skid_r;
        skid_vld_r <= 1'b0;
      end
    end else if (res_fire) begin
      if (!out_vld_r || pop) begin
        out_r <= res;
        out_vld_r <= 1'b1;
      end else begin
        skid_r <= res;
        skid_vld_r <= 1'b1;
      end
    end else if (pop) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.outcome          = out_r.outcome;
  assign out_ch.frame_header     = out_r.frame_header;
  assign out_ch.opcode           = out_r.opcode;
  assign out_ch.source_address   = out_r.source_address;
  assign out_ch.payload_length   = out_r.payload_length;
  assign out_ch.settings_updated = out_r.settings_updated;
  assign out_ch.light_sensor_on  = out_r.light_sensor_on;
  assign out_ch.motion_sensor_on = out_r.motion_sensor_on;
  assign out_ch.mute_on          = out_r.mute_on;
  assign out_ch.hello_request    = out_r.hello_request;

endmodule
